// ===== rtl/imm_pkg.sv =====
// ----------------------------------------------------------------------------
// imm_pkg
// Shared constants, types and helpers for the integer matrix multiplier.
// ----------------------------------------------------------------------------
package imm_pkg;

  // Matrix dimension (square), legal range 2..4
  localparam int DIM       = 4;
  localparam int IDX_W     = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int ADDR_W    = $clog2(DIM * DIM);
  localparam int DEPTH     = DIM * DIM;
  localparam int DATA_W    = 32;

  // Port field widths, fixed by the interface
  localparam int OP_W      = 2;
  localparam int FIELD_IDX_W = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIM - 1);

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_HOLD
  } state_t;

  // One read issue from the sequencer into the multiply-accumulate path
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } issue_t;

  // Row-major element address
  function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
    logic [ADDR_W-1:0] r;
    r = ADDR_W'(row);
    return r * ADDR_W'(DIM) + ADDR_W'(col);
  endfunction

endpackage

// ===== rtl/imm_ram.sv =====
// ----------------------------------------------------------------------------
// imm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module imm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/imm_mac.sv =====
// ----------------------------------------------------------------------------
// imm_mac
// Multiply-accumulate path: RAM data stage, product register, accumulator.
// ----------------------------------------------------------------------------
module imm_mac (
  input  logic                       clk,
  input  logic                       rst,
  input  imm_pkg::issue_t            issue,
  input  logic [imm_pkg::DATA_W-1:0] a_data,
  input  logic [imm_pkg::DATA_W-1:0] b_data,
  output logic                       done,
  output logic [imm_pkg::DATA_W-1:0] acc
);
  import imm_pkg::*;

  issue_t            stage1;   // aligned with RAM read data
  issue_t            stage2;   // aligned with product register
  logic [DATA_W-1:0] prod;
  logic [DATA_W-1:0] acc_next;

  // low word only: wraps mod 2^32, same bits signed or unsigned
  always_ff @(posedge clk) begin
    prod <= DATA_W'(a_data * b_data);
  end

  assign acc_next = stage2.first ? prod : acc + prod;

  always_ff @(posedge clk) begin
    if (stage2.valid) begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= '0;
      stage2 <= '0;
      done   <= 1'b0;
    end else begin
      stage1 <= issue;
      stage2 <= stage1;
      done   <= stage2.valid && stage2.last;
    end
  end

endmodule

// ===== rtl/imm_ctrl.sv =====
// ----------------------------------------------------------------------------
// imm_ctrl
// Compute sequencer: walks (row, col, k), issues RAM reads, hands results
// to the output register.
// ----------------------------------------------------------------------------
module imm_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      mac_done,
  input  logic                      out_free,
  output logic                      busy,
  output imm_pkg::issue_t           issue,
  output logic [imm_pkg::ADDR_W-1:0] a_raddr,
  output logic [imm_pkg::ADDR_W-1:0] b_raddr,
  output logic                      load,
  output logic [imm_pkg::IDX_W-1:0] res_row,
  output logic [imm_pkg::IDX_W-1:0] res_col,
  output logic                      res_last
);
  import imm_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] row;
  logic [IDX_W-1:0] col;
  logic [IDX_W-1:0] k;
  logic             final_elem;

  assign final_elem = (row == IDX_LAST) && (col == IDX_LAST);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (start) state_next = ST_ISSUE;
      ST_ISSUE: if (k == IDX_LAST) state_next = ST_DRAIN;
      ST_DRAIN: if (mac_done) state_next = ST_HOLD;
      ST_HOLD:  if (out_free) state_next = final_elem ? ST_IDLE : ST_ISSUE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy        = 1'b1;
    issue       = '0;
    load        = 1'b0;
    case (state)
      ST_IDLE:  busy = 1'b0;
      ST_ISSUE: begin
        issue.valid = 1'b1;
        issue.first = (k == '0);
        issue.last  = (k == IDX_LAST);
      end
      ST_DRAIN: ;
      ST_HOLD:  load = out_free;
      default:  busy = 1'b0;
    endcase
  end

  assign a_raddr  = elem_addr(row, k);
  assign b_raddr  = elem_addr(k, col);
  assign res_row  = row;
  assign res_col  = col;
  assign res_last = final_elem;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      row   <= '0;
      col   <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          row <= '0;
          col <= '0;
          k   <= '0;
        end
        ST_ISSUE: k <= (k == IDX_LAST) ? '0 : k + 1'b1;
        ST_HOLD: begin
          if (out_free) begin
            if (col == IDX_LAST) begin
              col <= '0;
              row <= (row == IDX_LAST) ? '0 : row + 1'b1;
            end else begin
              col <= col + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/integer_matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// integer_matrix_multiply
// Square signed 32-bit integer matrix multiplier, C = A x B, DIM x DIM.
// ----------------------------------------------------------------------------
// Matrices A and B live in two RAMs of DIM*DIM words each. A write beat
// (operation 0 for A, 1 for B) stores one element; write beats are taken
// back to back. A compute beat (operation 2) streams DIM*DIM result beats
// in row-major order, last set on the final one. For each result the
// sequencer issues one A and one B read per term through the single RAM
// read ports; the terms then pass the RAM read register, the product
// register and the accumulator, and the sum is loaded into the output
// register before the reads for the next result begin. in_stall is high
// while a compute is in progress, including any output stall. Products
// and sums wrap modulo 2^32. Operation 3 and writes with an index not
// below DIM are dropped. RAM contents are undefined until written; a
// compute must only touch written elements. Writes and compute reads never
// overlap in time, so the RAMs need no forwarding.
// ----------------------------------------------------------------------------
module integer_matrix_multiply (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [imm_pkg::OP_W-1:0]        operation,
  input  logic [imm_pkg::FIELD_IDX_W-1:0] row_index,
  input  logic [imm_pkg::FIELD_IDX_W-1:0] col_index,
  input  logic signed [imm_pkg::DATA_W-1:0] element_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [imm_pkg::FIELD_IDX_W-1:0] out_row,
  output logic [imm_pkg::FIELD_IDX_W-1:0] out_col,
  output logic signed [imm_pkg::DATA_W-1:0] product_value,
  output logic                            last
);
  import imm_pkg::*;

  logic              in_accept;
  logic              idx_ok;
  logic [ADDR_W-1:0] waddr;
  logic              we_a;
  logic              we_b;
  logic              start;

  logic              busy;
  issue_t            issue;
  logic [ADDR_W-1:0] a_raddr;
  logic [ADDR_W-1:0] b_raddr;
  logic [DATA_W-1:0] a_data;
  logic [DATA_W-1:0] b_data;
  logic              mac_done;
  logic [DATA_W-1:0] acc;
  logic              load;
  logic              out_free;
  logic [IDX_W-1:0]  res_row;
  logic [IDX_W-1:0]  res_col;
  logic              res_last;

  // input beat decode
  assign in_stall  = busy;
  assign in_accept = in_valid && !in_stall;
  assign idx_ok    = (int'(row_index) < DIM) && (int'(col_index) < DIM);
  assign waddr     = elem_addr(IDX_W'(row_index), IDX_W'(col_index));
  assign we_a      = in_accept && (operation == OP_WRITE_A) && idx_ok;
  assign we_b      = in_accept && (operation == OP_WRITE_B) && idx_ok;
  assign start     = in_accept && (operation == OP_COMPUTE);

  imm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (element_value),
    .raddr (a_raddr),
    .rdata (a_data)
  );

  imm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (element_value),
    .raddr (b_raddr),
    .rdata (b_data)
  );

  imm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .mac_done (mac_done),
    .out_free (out_free),
    .busy     (busy),
    .issue    (issue),
    .a_raddr  (a_raddr),
    .b_raddr  (b_raddr),
    .load     (load),
    .res_row  (res_row),
    .res_col  (res_col),
    .res_last (res_last)
  );

  imm_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .issue  (issue),
    .a_data (a_data),
    .b_data (b_data),
    .done   (mac_done),
    .acc    (acc)
  );

  // output register: free when empty or its beat is taken this cycle
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_row       <= FIELD_IDX_W'(res_row);
      out_col       <= FIELD_IDX_W'(res_col);
      product_value <= acc;
      last          <= res_last;
    end
  end

endmodule
